@@ src/iprl_pkg.sv @@
// ----------------------------------------------------------------------------
// iprl_pkg
// Shared types and constants for the address range operator lookup.
// ----------------------------------------------------------------------------
package iprl_pkg;

	localparam int PREFIX_W   = 24;
	localparam int TAG_W      = 2;
	localparam int STATUS_W   = 2;
	localparam int ADDR_W     = 32;
	localparam int S_TDATA_W  = 72;
	localparam int M_TDATA_W  = 8;
	localparam int ENTRY_W    = 2 * PREFIX_W + TAG_W;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

	localparam logic [TAG_W-1:0] TAG_MAX = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} iprl_state_t;

	typedef struct packed {
		logic take;
		logic load_wr;
		logic scan_rd;
		logic res_ld;
	} iprl_cmd_t;

	typedef struct packed {
		logic is_lookup;
		logic cnt_zero;
		logic idx_last;
		logic out_free;
	} iprl_sts_t;

endpackage

@@ src/iprl_ram.sv @@
// ----------------------------------------------------------------------------
// iprl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module iprl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ src/iprl_ctrl.sv @@
// ----------------------------------------------------------------------------
// iprl_ctrl
// Sequencer: accepts a request, runs a load or a table scan, posts the result.
// ----------------------------------------------------------------------------
module iprl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  iprl_pkg::iprl_sts_t sts,
	output iprl_pkg::iprl_cmd_t cmd
);

	import iprl_pkg::*;

	iprl_state_t state_q;
	iprl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_LOAD;
				end
			end
			ST_LOAD: begin
				// request was latched on entry: a lookup branches off, a load writes
				if (sts.is_lookup) begin
					if (sts.cnt_zero) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_SCAN;
					end
				end else begin
					cmd.load_wr = 1'b1;
					state_d     = ST_DONE;
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.idx_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.res_ld = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ src/iprl_dp.sv @@
// ----------------------------------------------------------------------------
// iprl_dp
// Datapath: request registers, range table, scan comparator, result register.
// ----------------------------------------------------------------------------
module iprl_dp #(
	parameter int MAX_RANGES = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_command,
	input  logic [iprl_pkg::ADDR_W-1:0]   in_address,
	input  logic [iprl_pkg::ADDR_W-1:0]   in_range_last,
	input  logic [iprl_pkg::TAG_W-1:0]    in_operator_tag,
	input  iprl_pkg::iprl_cmd_t           cmd,
	output iprl_pkg::iprl_sts_t           sts,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [iprl_pkg::STATUS_W-1:0] out_status,
	output logic [iprl_pkg::TAG_W-1:0]    out_operator_code
);

	import iprl_pkg::*;

	localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int CW = $clog2(MAX_RANGES + 1);

	logic                cmd_q;
	logic [PREFIX_W-1:0] key_q;
	logic [PREFIX_W-1:0] end_q;
	logic [TAG_W-1:0]    tag_q;
	logic [CW-1:0]       count_q;
	logic [AW-1:0]       idx_q;
	logic                cmp_vld_s1;
	logic                hit_q;
	logic [TAG_W-1:0]    best_q;
	logic                rej_q;
	logic                full;

	logic [ENTRY_W-1:0]  rd_entry;
	logic [PREFIX_W-1:0] rd_start;
	logic [PREFIX_W-1:0] rd_end;
	logic [TAG_W-1:0]    rd_tag;
	logic                match;

	assign full = (count_q == CW'(MAX_RANGES));

	iprl_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_RANGES)
	) u_table (
		.clk   (clk),
		.we    (cmd.load_wr && !full),
		.waddr (count_q[AW-1:0]),
		.wdata ({tag_q, end_q, key_q}),
		.re    (cmd.scan_rd),
		.raddr (idx_q),
		.rdata (rd_entry)
	);

	assign rd_start = rd_entry[PREFIX_W-1:0];
	assign rd_end   = rd_entry[2*PREFIX_W-1:PREFIX_W];
	assign rd_tag   = rd_entry[ENTRY_W-1:2*PREFIX_W];
	assign match    = cmp_vld_s1 && (rd_start <= key_q) && (key_q <= rd_end);

	// request capture, prefix is the upper three octets
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			cmd_q <= in_command;
			key_q <= in_address[ADDR_W-1:ADDR_W-PREFIX_W];
			end_q <= in_range_last[ADDR_W-1:ADDR_W-PREFIX_W];
			tag_q <= in_operator_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			idx_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			hit_q      <= 1'b0;
			best_q     <= TAG_MAX;
			rej_q      <= 1'b0;
		end else begin
			cmp_vld_s1 <= cmd.scan_rd;
			if (cmd.take) begin
				idx_q  <= '0;
				hit_q  <= 1'b0;
				best_q <= TAG_MAX;
			end
			if (cmd.scan_rd) begin
				idx_q <= idx_q + AW'(1);
			end
			if (match) begin
				hit_q <= 1'b1;
				if (!hit_q || (rd_tag < best_q)) begin
					best_q <= rd_tag;
				end
			end
			if (cmd.load_wr) begin
				rej_q <= full;
				if (!full) begin
					count_q <= count_q + CW'(1);
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.res_ld) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_ld) begin
			if (cmd_q == CMD_LOAD) begin
				out_status        <= rej_q ? STATUS_FULL : STATUS_OK;
				out_operator_code <= '0;
			end else begin
				out_status        <= hit_q ? STATUS_OK : STATUS_MISS;
				out_operator_code <= hit_q ? best_q : '0;
			end
		end
	end

	assign sts.is_lookup = (cmd_q == CMD_LOOKUP);
	assign sts.cnt_zero  = (count_q == '0);
	assign sts.idx_last  = ((CW'(idx_q) + CW'(1)) == count_q);
	assign sts.out_free  = !out_valid || out_ready;

endmodule

@@ src/ip_range_operator_lookup.sv @@
// ----------------------------------------------------------------------------
// ip_range_operator_lookup
// Table of IPv4 prefix ranges tagged with operator codes; load and lookup.
// ----------------------------------------------------------------------------
// Input stream s_*: one request per handshake. s_tuser selects load (0) or
// lookup (1). A load appends the range [address, range_last] with its tag;
// a lookup returns the lowest tag of all ranges holding the address. Only
// the upper three octets take part in any compare.
// Output stream m_*: exactly one response per request, in request order.
// Sequence: a load passes the load and done states before its response is
// registered. A lookup walks the stored entries through one RAM read port and
// one comparator, one entry a cycle, then drains the last compare; an empty
// table skips the scan. One request is in flight at a time.
// The response sits in an output register; the next request is accepted
// while it waits, but that request's response holds until m_tready frees it.
// Reset clears the entry count and all handshake state; table contents are
// not cleared and are never read before they are written.
// ----------------------------------------------------------------------------
module ip_range_operator_lookup #(
	parameter int MAX_RANGES = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [31:0] address, [63:32] range_last, [65:64] operator_tag, rest zero
	input  logic [iprl_pkg::S_TDATA_W-1:0]   s_tdata,
	// [0] command
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [1:0] operator_code, rest zero
	output logic [iprl_pkg::M_TDATA_W-1:0]   m_tdata,
	// [1:0] status
	output logic [iprl_pkg::STATUS_W-1:0]    m_tuser
);

	import iprl_pkg::*;

	iprl_cmd_t        cmd;
	iprl_sts_t        sts;
	logic [TAG_W-1:0] operator_code;

	iprl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	iprl_dp #(
		.MAX_RANGES(MAX_RANGES)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_command        (s_tuser),
		.in_address        (s_tdata[ADDR_W-1:0]),
		.in_range_last     (s_tdata[2*ADDR_W-1:ADDR_W]),
		.in_operator_tag   (s_tdata[2*ADDR_W+TAG_W-1:2*ADDR_W]),
		.cmd               (cmd),
		.sts               (sts),
		.out_valid         (m_tvalid),
		.out_ready         (m_tready),
		.out_status        (m_tuser),
		.out_operator_code (operator_code)
	);

	assign m_tdata = {{(M_TDATA_W-TAG_W){1'b0}}, operator_code};

endmodule

@@ tb/iprl_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// iprl_checker
// Watches both streams of the range lookup, keeps its own range table and
// predicts one response per request; compares responses field by field.
// ----------------------------------------------------------------------------
module iprl_checker #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [iprl_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic                             s_tuser,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [iprl_pkg::M_TDATA_W-1:0]   m_tdata,
	input  logic [iprl_pkg::STATUS_W-1:0]    m_tuser,
	output int                               mismatches,
	output int                               outstanding
);
	import iprl_pkg::*;

	typedef struct packed {
		logic [PREFIX_W-1:0] first;
		logic [PREFIX_W-1:0] last;
		logic [TAG_W-1:0]    tag;
	} range_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [TAG_W-1:0]    code;
	} answer_t;

	range_t  ranges[TABLE_DEPTH];
	int      range_count;
	answer_t answers_due[$];

	function automatic answer_t predict_answer(input logic cmd,
		input logic [ADDR_W-1:0] addr, input logic [ADDR_W-1:0] last_addr,
		input logic [TAG_W-1:0] tag);
		answer_t             ans;
		logic [PREFIX_W-1:0] key;
		logic [TAG_W-1:0]    best;
		logic                hit;
		ans.status = STATUS_OK;
		ans.code   = '0;
		key        = addr[ADDR_W-1 -: PREFIX_W];
		best       = TAG_MAX;
		hit        = 1'b0;
		if (cmd == CMD_LOAD) begin
			if (range_count >= TABLE_DEPTH) begin
				ans.status = STATUS_FULL;
			end else begin
				ranges[range_count].first = key;
				ranges[range_count].last  = last_addr[ADDR_W-1 -: PREFIX_W];
				ranges[range_count].tag   = tag;
				range_count++;
			end
		end else begin
			for (int i = 0; i < range_count; i++) begin
				if (ranges[i].first <= key && key <= ranges[i].last) begin
					if (!hit || ranges[i].tag < best)
						best = ranges[i].tag;
					hit = 1'b1;
				end
			end
			if (hit)
				ans.code = best;
			else
				ans.status = STATUS_MISS;
		end
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			range_count = 0;
			answers_due.delete();
			mismatches  = 0;
		end else begin
			// responses trail their requests, so pop first
			if (m_tvalid && m_tready) begin
				if (answers_due.size() == 0) begin
					$display("%0t: expected no response, actual status %0d data %0h",
						$time, m_tuser, m_tdata);
					mismatches++;
				end else begin
					want = answers_due.pop_front();
					if (m_tuser !== want.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							want.status, m_tuser);
						mismatches++;
					end
					if (m_tdata !== {{(M_TDATA_W-TAG_W){1'b0}}, want.code}) begin
						$display("%0t: operator code expected %0h actual %0h", $time,
							{{(M_TDATA_W-TAG_W){1'b0}}, want.code}, m_tdata);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready)
				answers_due.insert(answers_due.size(), predict_answer(s_tuser,
					s_tdata[ADDR_W-1:0], s_tdata[2*ADDR_W-1:ADDR_W],
					s_tdata[2*ADDR_W+TAG_W-1:2*ADDR_W]));
		end
		outstanding = answers_due.size();
	end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the range lookup: directed loads and lookups on the table
// edges, then random loads and lookups, mostly aimed at stored ranges, and loads
// into a full table, with bursty requests and a stalling response side.
// ----------------------------------------------------------------------------
module tb_top;
	import iprl_pkg::*;

	localparam int TABLE_DEPTH  = 256;
	localparam int RANDOM_REQS  = 1525;
	localparam int CYCLE_LIMIT  = 3_000_000;
	localparam int DRAIN_CYCLES = TABLE_DEPTH + 16;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 700;

	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_BLOCKED
	} rx_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [STATUS_W-1:0]   m_tuser;

	int mismatches;
	int outstanding;
	int cycle_count = 0;
	int sent        = 0;
	int loads_sent  = 0;
	int burst_left  = 0;
	bit hold_req    = 1'b0;

	// stored range bounds, used only to aim lookups
	logic [PREFIX_W-1:0] loaded_first[$];
	logic [PREFIX_W-1:0] loaded_last[$];

	always #6 clk = ~clk;

	ip_range_operator_lookup #(
		.MAX_RANGES(TABLE_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	iprl_checker #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// called at a falling edge; returns at a falling edge
	task automatic send_req(input logic cmd, input logic [ADDR_W-1:0] addr,
		input logic [ADDR_W-1:0] last_addr, input logic [TAG_W-1:0] tag);
		s_tuser  = cmd;
		s_tdata  = {{(S_TDATA_W-2*ADDR_W-TAG_W){1'b0}}, tag, last_addr, addr};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		sent++;
		if (sent == HOLD_AT)
			hold_req = 1'b1;
		if (cmd == CMD_LOAD) begin
			loads_sent++;
			if (loaded_first.size() < TABLE_DEPTH) begin
				loaded_first.insert(loaded_first.size(), addr[ADDR_W-1 -: PREFIX_W]);
				loaded_last.insert(loaded_last.size(), last_addr[ADDR_W-1 -: PREFIX_W]);
			end
		end
		@(negedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = $urandom_range(1, 16);
		end
	endtask

	task automatic send_random_load();
		logic [PREFIX_W-1:0] first;
		logic [PREFIX_W-1:0] last_p;
		first = PREFIX_W'($urandom);
		case ($urandom_range(0, 19))
			0: last_p = PREFIX_W'(first - $urandom_range(1, 1000));
			1: last_p = PREFIX_W'($urandom);
			2, 3, 4: last_p = PREFIX_W'(first + $urandom_range(0, 4095));
			default: last_p = PREFIX_W'(first + $urandom_range(0, 15));
		endcase
		send_req(CMD_LOAD, {first, 8'($urandom)}, {last_p, 8'($urandom)},
			TAG_W'($urandom_range(0, 3)));
	endtask

	task automatic send_aimed_lookup();
		int                  idx;
		logic [PREFIX_W-1:0] first;
		logic [PREFIX_W-1:0] last_p;
		logic [PREFIX_W-1:0] key;
		idx    = $urandom_range(0, loaded_first.size() - 1);
		first  = loaded_first[idx];
		last_p = loaded_last[idx];
		case ($urandom_range(0, 9))
			0: key = first - 1'b1;
			1: key = last_p + 1'b1;
			2: key = first;
			3: key = last_p;
			default: begin
				if (first <= last_p)
					key = PREFIX_W'(first + $urandom_range(0, 32'(last_p - first)));
				else
					key = PREFIX_W'($urandom);
			end
		endcase
		send_req(CMD_LOOKUP, {key, 8'($urandom)}, $urandom,
			TAG_W'($urandom_range(0, 3)));
	endtask

	// response side: random stall patterns plus one long hold-off
	initial begin : receiver
		rx_mode_t mode;
		int       mode_left;
		int       hold_left;
		bit       hold_done;
		mode      = RX_OPEN;
		mode_left = 0;
		hold_left = 0;
		hold_done = 1'b0;
		m_tready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready = 1'b0;
			end else begin
				if (mode_left <= 0) begin
					mode      = rx_mode_t'($urandom_range(0, 3));
					mode_left = (mode == RX_BLOCKED) ? $urandom_range(5, 60) :
						$urandom_range(20, 300);
				end
				mode_left--;
				case (mode)
					RX_OPEN:    m_tready = 1'b1;
					RX_COIN:    m_tready = ($urandom_range(0, 1) == 1);
					RX_SPARSE:  m_tready = ($urandom_range(0, 7) == 0);
					RX_BLOCKED: m_tready = 1'b0;
					default:    m_tready = 1'b1;
				endcase
			end
		end
	end

	initial begin : stimulus
		int pick;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tuser  = CMD_LOAD;
		s_tdata  = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n     = 1'b1;
		burst_left = $urandom_range(1, 16);
		@(negedge clk);

		// empty table
		send_req(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 2'd0);
		send_req(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3);
		// lowest and highest prefix, reversed range, tag three, duplicates
		send_req(CMD_LOAD, 32'h0000_0000, 32'h0000_00FF, 2'd1);
		send_req(CMD_LOAD, 32'hFFFF_FF00, 32'hFFFF_FFFF, 2'd2);
		send_req(CMD_LOAD, 32'hFFFF_FFFF, 32'h0000_0000, 2'd0);
		send_req(CMD_LOAD, 32'h0A00_0000, 32'h0A00_FFFF, 2'd3);
		send_req(CMD_LOAD, 32'h0A00_0000, 32'h0A00_FFFF, 2'd3);
		send_req(CMD_LOAD, 32'h0A00_0077, 32'h0A00_0F12, 2'd1);
		send_req(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 2'd0);
		send_req(CMD_LOOKUP, 32'h0000_00FF, 32'hFFFF_FFFF, 2'd3);
		send_req(CMD_LOOKUP, 32'h0000_0100, 32'h0000_0000, 2'd0);
		send_req(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 2'd0);
		send_req(CMD_LOOKUP, 32'hFFFF_FF00, 32'h0000_0000, 2'd1);
		send_req(CMD_LOOKUP, 32'hFFFF_FEFF, 32'h0000_0000, 2'd0);
		send_req(CMD_LOOKUP, 32'h0A00_FF37, 32'h0000_0000, 2'd0);
		send_req(CMD_LOOKUP, 32'h0A00_0512, 32'h0000_0000, 2'd0);
		send_req(CMD_LOOKUP, 32'h0A01_0000, 32'h0000_0000, 2'd0);
		// fourth octet ignored on both ends of the range
		send_req(CMD_LOAD, 32'h0A00_00CD, 32'h0A00_00AB, 2'd0);
		send_req(CMD_LOOKUP, 32'h0A00_00EE, 32'h0000_0000, 2'd0);
		send_req(CMD_LOOKUP, 32'h0A00_0100, 32'h0000_0000, 2'd0);
		send_req(CMD_LOOKUP, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 2'd3);

		for (int n = 0; n < RANDOM_REQS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 30)
				send_random_load();
			else if (pick < 85)
				send_aimed_lookup();
			else
				send_req(CMD_LOOKUP, $urandom, $urandom, TAG_W'($urandom_range(0, 3)));
		end
		// make sure loads into a full table are seen
		while (loads_sent <= TABLE_DEPTH + 2)
			send_random_load();
		send_aimed_lookup();
		s_tvalid = 1'b0;

		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
